// ===== sv/b32d_pkg.sv =====
// ============================================================================
// b32d_pkg: shared definitions for the bech32 address decoder
// Charset and prefix tables, status codes, result item and queue push types.
// ============================================================================
package b32d_pkg;

   // Address format limits
   localparam int CHECKSUM_SYMBOLS = 6;
   localparam int MAX_CHARS        = 90;
   localparam int MIN_CHARS        = 8;
   localparam int PREFIX_LEN       = 4;
   localparam int MIN_DATA_BYTES   = 2;
   localparam int MAX_DATA_BYTES   = 40;

   // State widths
   localparam int POS_W   = 7;
   localparam int LEN_W   = POS_W + 1;
   localparam int ACC_W   = 12;
   localparam int SYM_W   = 5;
   localparam int COUNT_W = 6;

   localparam logic [POS_W-1:0]   POS_MAX   = '1;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // Result queue
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = 2;
   localparam int RSP_CNT_W = 3;

   // Status and error codes
   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_BAD_PFX   = 3'd1;
   localparam logic [2:0] STATUS_BAD_LEN   = 3'd2;
   localparam logic [2:0] STATUS_BAD_CHAR  = 3'd3;
   localparam logic [2:0] STATUS_BAD_DATA  = 3'd4;

   // Result kinds
   localparam logic KIND_BYTE   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   localparam logic [7:0] PREFIX [PREFIX_LEN] = '{"b", "c", "1", "q"};

   localparam logic [7:0] CHARSET [32] = '{
      "q", "p", "z", "r", "y", "9", "x", "8",
      "g", "f", "2", "t", "v", "d", "w", "0",
      "s", "3", "j", "n", "5", "4", "k", "h",
      "c", "e", "6", "m", "u", "a", "7", "l"
   };

   typedef struct packed {
      logic         kind;
      logic [7:0]   out_byte;
      logic [2:0]   status;
      logic [5:0]   program_length;
      logic         end_mark;
   } rsp_item_type;

   // Up to two results per character, in order: item[0] first
   typedef struct packed {
      logic [1:0]             count;
      rsp_item_type [1:0]     item;
   } rsp_push_type;

   // Returns {valid, symbol}; upper-case letters fold to lower case
   function automatic logic [SYM_W:0] symbol_lookup(input logic [7:0] c);
      logic [7:0]     folded;
      logic [SYM_W:0] result;
      folded = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
      result = '0;
      for (int i = 0; i < 32; i++) begin
         if (folded == CHARSET[i]) begin
            result = {1'b1, SYM_W'(i)};
         end
      end
      return result;
   endfunction

endpackage

// ===== sv/b32d_if.sv =====
// ============================================================================
// b32d_req_if / b32d_rsp_if: valid/ready channels of the address decoder
// Character stream in, program bytes and status out.
// ============================================================================
interface b32d_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] character;
   logic       final_char;

   modport source(output valid, character, final_char, input ready);
   modport sink(input valid, character, final_char, output ready);
endinterface

interface b32d_rsp_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] out_byte;
   logic [2:0] status;
   logic [5:0] program_length;
   logic       end_mark;

   modport source(output valid, kind, out_byte, status, program_length, end_mark,
                  input ready);
   modport sink(input valid, kind, out_byte, status, program_length, end_mark,
                output ready);
endinterface

// ===== sv/b32d_core.sv =====
// ============================================================================
// b32d_core: character register and single-pass decode step
// Prefix check, charset map, checksum delay line, 5-to-8 regroup, status.
// ============================================================================
module b32d_core (
   input  logic                  clock,
   input  logic                  reset,
   b32d_req_if.sink              req_ch,
   input  logic                  room,
   output b32d_pkg::rsp_push_type push
);
   import b32d_pkg::*;

   localparam logic [POS_W-1:0] POS_DATA = POS_W'(PREFIX_LEN + CHECKSUM_SYMBOLS);

   // Input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] char_ff;
   logic       final_ff;
   logic       fire;

   // Decoder state
   logic [POS_W-1:0]   char_position_ff, char_position_in;
   logic [2:0]         error_code_ff, error_code_in;
   logic [SYM_W-1:0]   held_symbols_ff [CHECKSUM_SYMBOLS];
   logic [SYM_W-1:0]   held_symbols_in [CHECKSUM_SYMBOLS];
   logic [ACC_W-1:0]   bit_accumulator_ff, bit_accumulator_in;
   logic [2:0]         pending_bits_ff, pending_bits_in;
   logic [COUNT_W-1:0] data_byte_count_ff, data_byte_count_in;

   logic [LEN_W-1:0] len;
   logic [SYM_W:0]   sym;
   logic [3:0]       pb_sum;
   logic [2:0]       status;

   // Work on the held character only when the queue can take two results
   assign fire         = in_valid_ff && room;
   assign req_ch.ready = !in_valid_ff || fire;
   assign in_valid_in  = req_ch.valid ? 1'b1 : (in_valid_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_ch.valid && req_ch.ready) begin
         char_ff  <= req_ch.character;
         final_ff <= req_ch.final_char;
      end
   end

   // Decode step
   always_comb begin
      char_position_in   = char_position_ff;
      error_code_in      = error_code_ff;
      held_symbols_in    = held_symbols_ff;
      bit_accumulator_in = bit_accumulator_ff;
      pending_bits_in    = pending_bits_ff;
      data_byte_count_in = data_byte_count_ff;
      push               = '0;
      status             = STATUS_OK;
      pb_sum             = '0;
      len                = {1'b0, char_position_ff} + LEN_W'(1);
      sym                = symbol_lookup(char_ff);

      if (char_position_ff < POS_W'(PREFIX_LEN)) begin
         // Prefix; version byte 0 once it completes cleanly
         if (char_ff != PREFIX[char_position_ff[1:0]]) begin
            if (error_code_ff == STATUS_OK) begin
               error_code_in = STATUS_BAD_PFX;
            end
         end else if (char_position_ff == POS_W'(PREFIX_LEN - 1) &&
                      error_code_ff == STATUS_OK) begin
            push.item[0].kind = KIND_BYTE;
            push.count        = 2'd1;
         end
      end else if (!sym[SYM_W]) begin
         if (error_code_ff == STATUS_OK) begin
            error_code_in = STATUS_BAD_CHAR;
         end
      end else if (error_code_ff == STATUS_OK && len <= LEN_W'(MAX_CHARS)) begin
         // Symbol leaving the delay line goes into the regrouper
         if (char_position_ff >= POS_DATA) begin
            bit_accumulator_in = {bit_accumulator_ff[ACC_W-SYM_W-1:0],
                                  held_symbols_ff[CHECKSUM_SYMBOLS-1]};
            pb_sum = {1'b0, pending_bits_ff} + 4'd5;
            if (pb_sum >= 4'd8) begin
               pending_bits_in       = 3'(pb_sum - 4'd8);
               push.item[0].kind     = KIND_BYTE;
               push.item[0].out_byte = 8'(bit_accumulator_in >> pending_bits_in);
               push.count            = 2'd1;
               if (data_byte_count_ff != COUNT_MAX) begin
                  data_byte_count_in = data_byte_count_ff + COUNT_W'(1);
               end
            end else begin
               pending_bits_in = pb_sum[2:0];
            end
         end
         for (int i = CHECKSUM_SYMBOLS - 1; i > 0; i--) begin
            held_symbols_in[i] = held_symbols_ff[i-1];
         end
         held_symbols_in[0] = sym[SYM_W-1:0];
      end

      if (char_position_ff != POS_MAX) begin
         char_position_in = char_position_ff + POS_W'(1);
      end

      // Last character: status result, then clear for the next address
      if (final_ff) begin
         if (error_code_in == STATUS_BAD_PFX || len < LEN_W'(PREFIX_LEN)) begin
            status = STATUS_BAD_PFX;
         end else if (len < LEN_W'(MIN_CHARS) || len > LEN_W'(MAX_CHARS)) begin
            status = STATUS_BAD_LEN;
         end else if (error_code_in == STATUS_BAD_CHAR) begin
            status = STATUS_BAD_CHAR;
         end else if (data_byte_count_in < COUNT_W'(MIN_DATA_BYTES) ||
                      data_byte_count_in > COUNT_W'(MAX_DATA_BYTES)) begin
            status = STATUS_BAD_DATA;
         end else begin
            status = STATUS_OK;
         end
         push.item[push.count[0]].kind     = KIND_STATUS;
         push.item[push.count[0]].status   = status;
         push.item[push.count[0]].end_mark = 1'b1;
         if (status == STATUS_OK) begin
            push.item[push.count[0]].program_length = data_byte_count_in + COUNT_W'(1);
         end
         push.count         = push.count + 2'd1;
         char_position_in   = '0;
         error_code_in      = STATUS_OK;
         bit_accumulator_in = '0;
         pending_bits_in    = '0;
         data_byte_count_in = '0;
         for (int i = 0; i < CHECKSUM_SYMBOLS; i++) begin
            held_symbols_in[i] = '0;
         end
      end

      if (!fire) begin
         push.count = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         char_position_ff   <= '0;
         error_code_ff      <= STATUS_OK;
         bit_accumulator_ff <= '0;
         pending_bits_ff    <= '0;
         data_byte_count_ff <= '0;
         for (int i = 0; i < CHECKSUM_SYMBOLS; i++) begin
            held_symbols_ff[i] <= '0;
         end
      end else if (fire) begin
         char_position_ff   <= char_position_in;
         error_code_ff      <= error_code_in;
         bit_accumulator_ff <= bit_accumulator_in;
         pending_bits_ff    <= pending_bits_in;
         data_byte_count_ff <= data_byte_count_in;
         held_symbols_ff    <= held_symbols_in;
      end
   end

   // A status result ends the address and clears position and error
   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      fire && final_ff |=> char_position_ff == '0 && error_code_ff == STATUS_OK)
      else $error("state not cleared after final character");

   // Only the final character can give two results
   a_two_only_final: assert property (@(posedge clock) disable iff (reset)
      fire && !final_ff |-> push.count <= 2'd1)
      else $error("two results without final character");

   // With two results the status comes second
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      push.count == 2'd2 |-> push.item[1].kind == KIND_STATUS &&
                             push.item[0].kind == KIND_BYTE)
      else $error("result order wrong");

endmodule

// ===== sv/b32d_rsp_queue.sv =====
// ============================================================================
// b32d_rsp_queue: result queue
// Takes up to two results per cycle, hands out one per transfer.
// ============================================================================
module b32d_rsp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  b32d_pkg::rsp_push_type push,
   output logic                   room,
   b32d_rsp_if.source             rsp_ch
);
   import b32d_pkg::*;

   rsp_item_type         entry_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0] count_ff, count_in;
   logic                 pop;
   rsp_item_type         head;

   // Room for the worst case of two results
   assign room = count_ff <= RSP_CNT_W'(RSP_DEPTH - 2);
   assign pop  = rsp_ch.valid && rsp_ch.ready;

   assign wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(push.count);
   assign rd_ptr_in = rd_ptr_ff + RSP_PTR_W'(pop);
   assign count_in  = count_ff + RSP_CNT_W'(push.count) - RSP_CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.item[0];
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_ff + RSP_PTR_W'(1)] <= push.item[1];
      end
   end

   // Head of queue drives the result channel
   assign head                  = entry_ff[rd_ptr_ff];
   assign rsp_ch.valid          = count_ff != '0;
   assign rsp_ch.kind           = head.kind;
   assign rsp_ch.out_byte       = head.out_byte;
   assign rsp_ch.status         = head.status;
   assign rsp_ch.program_length = head.program_length;
   assign rsp_ch.end_mark       = head.end_mark;

   // Never pushed beyond capacity
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> room)
      else $error("result queue overflow");

   // Occupancy tracks the pointers
   a_count_ptrs: assert property (@(posedge clock) disable iff (reset)
      RSP_PTR_W'(count_ff) == RSP_PTR_W'(wr_ptr_ff - rd_ptr_ff) &&
      count_ff <= RSP_CNT_W'(RSP_DEPTH))
      else $error("queue count out of step with pointers");

endmodule

// ===== sv/bech32_address_decoder.sv =====
// ============================================================================
// bech32_address_decoder: streaming decoder for bc1q segwit v0 addresses
// One character per transfer in; program bytes and a final status out.
// ============================================================================
//
//   channel   dir  handshake              payload
//   req_ch    in   valid/ready            character, final_char
//   rsp_ch    out  valid/ready            kind, out_byte, status,
//                                         program_length, end_mark
//
// One character per cycle while the queue has room: it is registered, decoded
// in one pass and its results are registered into a four-entry queue whose
// head drives rsp_ch. Each character gives at most one byte, the final one
// also a status, so the output channel (one result a cycle) sets the
// sustained rate. A stalled rsp_ch holds req_ch once the queue lacks room
// for two results. Synchronous reset clears state.
//
module bech32_address_decoder (
   input  logic       clock,
   input  logic       reset,
   b32d_req_if.sink   req_ch,
   b32d_rsp_if.source rsp_ch
);
   import b32d_pkg::*;

   rsp_push_type push;
   logic         room;

   b32d_core u_core (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .room   (room),
      .push   (push)
   );

   b32d_rsp_queue u_rsp_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .room   (room),
      .rsp_ch (rsp_ch)
   );

endmodule
